// ----- rtl/osr_pkg.sv -----
// Shared types, constants and fixed-point helpers for the orientation step rotator.
package osr_pkg;

	localparam int VEC_W = 20;
	localparam int ACC_W = 64;
	localparam int MB_W  = 22;
	localparam int CNT_W = 5;
	localparam int COEF_W = 16;
	localparam longint INV_SQRT2_Q30 = 64'sd759250125;

	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [MB_W-1:0]  mb_t;

	localparam acc_t VEC_MAX = acc_t'(524287);
	localparam acc_t VEC_MIN = -acc_t'(524288);

	function automatic acc_t rnd(input acc_t x, input int sh);
		acc_t h;
		h = acc_t'(1) <<< (sh - 1);
		if (sh == 0) begin
			return x;
		end
		return (x + h) >>> sh;
	endfunction

	function automatic vec_t sat20(input acc_t x);
		if (x > VEC_MAX) begin
			return vec_t'(VEC_MAX);
		end
		if (x < VEC_MIN) begin
			return vec_t'(VEC_MIN);
		end
		return x[VEC_W-1:0];
	endfunction

	// base axes N,NW,W,SW,S,SE,E,NE; x is always zero
	function automatic vec_t base_axis(input logic [2:0] d, input logic [1:0] c,
		input vec_t one, input vec_t r);
		vec_t y;
		vec_t z;
		case (d)
			3'd0: begin y = one;  z = '0;   end
			3'd1: begin y = r;    z = -r;   end
			3'd2: begin y = '0;   z = -one; end
			3'd3: begin y = -r;   z = -r;   end
			3'd4: begin y = -one; z = '0;   end
			3'd5: begin y = -r;   z = r;    end
			3'd6: begin y = '0;   z = one;  end
			default: begin y = r; z = r;    end
		endcase
		case (c)
			2'd1: return y;
			2'd2: return z;
			default: return '0;
		endcase
	endfunction

endpackage

// ----- rtl/osr_if.sv -----
// Request and response channel interfaces of the orientation step rotator.
interface osr_req_if;
	logic                valid;
	logic                ready;
	logic                cmd;
	logic [2:0]          direction;
	osr_pkg::vec_t       load_x;
	osr_pkg::vec_t       load_y;
	osr_pkg::vec_t       load_z;
	modport source(output valid, cmd, direction, load_x, load_y, load_z, input ready);
	modport sink(input valid, cmd, direction, load_x, load_y, load_z, output ready);
endinterface

interface osr_rsp_if;
	logic          valid;
	logic          ready;
	osr_pkg::vec_t out_x;
	osr_pkg::vec_t out_y;
	osr_pkg::vec_t out_z;
	modport source(output valid, out_x, out_y, out_z, input ready);
	modport sink(input valid, out_x, out_y, out_z, output ready);
endinterface

// ----- rtl/osr_mul.sv -----
// Bit-serial signed multiplier: one multiplier bit per cycle.
module osr_mul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  osr_pkg::acc_t  a,
	input  osr_pkg::mb_t   b,
	output logic           done,
	output osr_pkg::acc_t  p
);

	osr_pkg::acc_t acc_q;
	osr_pkg::acc_t a_q;
	osr_pkg::mb_t  b_q;
	logic [osr_pkg::CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic last;

	assign last = (cnt_q == osr_pkg::CNT_W'(osr_pkg::MB_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			// sign bit of the multiplier has negative weight
			if (b_q[0]) begin
				acc_q <= last ? acc_q - a_q : acc_q + a_q;
			end
			a_q <= a_q <<< 1;
			b_q <= b_q >>> 1;
		end
	end

	assign done = done_q;
	assign p    = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("multiply started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("done while busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q < osr_pkg::CNT_W'(osr_pkg::MB_W)))
		else $error("bit counter out of range");

endmodule

// ----- rtl/orientation_step_rotator.sv -----
// Top level: rotates position and axis table by a quaternion step with a serial multiplier.
// Load transaction: the accepted request passes to the done state, which writes the result
// register once the output register is free and returns to idle for the next accept;
// a rotate with an axis beyond the table takes the same path.
// Rotate transaction: seven setup products, then 18 products for the position and for each
// axis, issued one at a time to the single bit-serial multiplier, before the done state.
// One transaction at a time; the next is accepted while a result waits in the output register.
// Reset (async, active low) loads position (-1,0,0), the eight base axes and cos = sin = 23170.
module orientation_step_rotator #(
	parameter int NUM_DIRS  = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	osr_req_if.sink     req,
	osr_rsp_if.source   rsp
);

	localparam int IDX_W = $clog2(NUM_DIRS + 1);
	localparam int AX_W  = $clog2(NUM_DIRS);
	localparam osr_pkg::acc_t ONE_L = osr_pkg::acc_t'(osr_pkg::sat20(
		osr_pkg::acc_t'(1) <<< FRAC_BITS));
	localparam osr_pkg::acc_t R_L = osr_pkg::acc_t'(osr_pkg::sat20(
		osr_pkg::rnd(osr_pkg::INV_SQRT2_Q30, 30 - FRAC_BITS)));
	localparam osr_pkg::vec_t ONE_V = ONE_L[osr_pkg::VEC_W-1:0];
	localparam osr_pkg::vec_t R_V   = R_L[osr_pkg::VEC_W-1:0];

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_VEC   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [4:0] SU_U0  = 5'd0;
	localparam logic [4:0] SU_U1  = 5'd1;
	localparam logic [4:0] SU_U2  = 5'd2;
	localparam logic [4:0] SU_UU0 = 5'd3;
	localparam logic [4:0] SU_UU1 = 5'd4;
	localparam logic [4:0] SU_UU2 = 5'd5;
	localparam logic [4:0] SU_CC  = 5'd6;

	localparam logic [4:0] VS_DOT0 = 5'd0;
	localparam logic [4:0] VS_DOT1 = 5'd1;
	localparam logic [4:0] VS_DOT2 = 5'd2;
	localparam logic [4:0] VS_X0A  = 5'd3;
	localparam logic [4:0] VS_X0B  = 5'd4;
	localparam logic [4:0] VS_X1A  = 5'd5;
	localparam logic [4:0] VS_X1B  = 5'd6;
	localparam logic [4:0] VS_X2A  = 5'd7;
	localparam logic [4:0] VS_X2B  = 5'd8;
	localparam logic [4:0] VS_T0   = 5'd9;
	localparam logic [4:0] VS_T1   = 5'd10;
	localparam logic [4:0] VS_T2   = 5'd11;
	localparam logic [4:0] VS_DU0  = 5'd12;
	localparam logic [4:0] VS_KV0  = 5'd13;
	localparam logic [4:0] VS_DU1  = 5'd14;
	localparam logic [4:0] VS_KV1  = 5'd15;
	localparam logic [4:0] VS_DU2  = 5'd16;
	localparam logic [4:0] VS_KV2  = 5'd17;

	logic [1:0] state_q;
	logic [4:0] step_q;
	logic [IDX_W-1:0] vi_q;
	logic issued_q;

	logic [15:0] c_q;
	logic [15:0] s_q;
	osr_pkg::vec_t pos_q [3];
	osr_pkg::vec_t axis_q [NUM_DIRS][3];
	osr_pkg::vec_t a_q [3];
	osr_pkg::mb_t  u_q [3];
	osr_pkg::acc_t sum_q;
	osr_pkg::acc_t d_q;
	osr_pkg::acc_t k_q;
	osr_pkg::acc_t cr_q [3];

	logic rv_q;
	osr_pkg::vec_t ox_q;
	osr_pkg::vec_t oy_q;
	osr_pkg::vec_t oz_q;

	logic [IDX_W-1:0] vm1;
	logic [AX_W-1:0]  ax_idx;
	logic [AX_W-1:0]  dir_idx;
	osr_pkg::vec_t vsel [3];
	logic [4:0] s3;
	logic [4:0] s9;
	logic [4:0] s12;
	logic [1:0] ju;
	logic [1:0] jt;
	logic [1:0] jr;

	osr_pkg::acc_t op_a;
	osr_pkg::mb_t  op_b;
	logic mul_start;
	logic mul_done;
	osr_pkg::acc_t mul_p;

	osr_pkg::acc_t p_r15;
	osr_pkg::acc_t p2_r15;
	osr_pkg::acc_t k_val;
	osr_pkg::acc_t d_val;
	osr_pkg::vec_t res_val;
	logic wr_cfg;
	logic acc_req;
	logic out_free;

	assign pready = 1'b1;
	assign wr_cfg = psel & penable & pwrite;
	assign prdata = paddr[2] ? {16'b0, s_q} : {16'b0, c_q};

	assign vm1     = vi_q - 1'b1;
	assign ax_idx  = vm1[AX_W-1:0];
	assign dir_idx = AX_W'(req.direction);
	assign s3  = step_q - SU_UU0;
	assign s9  = step_q - VS_T0;
	assign s12 = step_q - VS_DU0;
	assign ju  = s3[1:0];
	assign jt  = s9[1:0];
	assign jr  = s12[2:1];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			vsel[j] = (vi_q == '0) ? pos_q[j] : axis_q[ax_idx][j];
		end
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		if (state_q == ST_SETUP) begin
			case (step_q)
				SU_U0, SU_U1, SU_U2: begin
					op_a = osr_pkg::acc_t'(a_q[step_q[1:0]]);
					op_b = osr_pkg::mb_t'({6'b0, s_q});
				end
				SU_UU0, SU_UU1, SU_UU2: begin
					op_a = osr_pkg::acc_t'(u_q[ju]);
					op_b = u_q[ju];
				end
				default: begin
					op_a = osr_pkg::acc_t'({48'b0, c_q});
					op_b = osr_pkg::mb_t'({6'b0, c_q});
				end
			endcase
		end else begin
			case (step_q)
				VS_DOT0, VS_DOT1, VS_DOT2: begin
					op_a = osr_pkg::acc_t'(u_q[step_q[1:0]]);
					op_b = osr_pkg::mb_t'(vsel[step_q[1:0]]);
				end
				VS_X0A: begin op_a = osr_pkg::acc_t'(u_q[1]); op_b = osr_pkg::mb_t'(vsel[2]); end
				VS_X0B: begin op_a = osr_pkg::acc_t'(u_q[2]); op_b = osr_pkg::mb_t'(vsel[1]); end
				VS_X1A: begin op_a = osr_pkg::acc_t'(u_q[2]); op_b = osr_pkg::mb_t'(vsel[0]); end
				VS_X1B: begin op_a = osr_pkg::acc_t'(u_q[0]); op_b = osr_pkg::mb_t'(vsel[2]); end
				VS_X2A: begin op_a = osr_pkg::acc_t'(u_q[0]); op_b = osr_pkg::mb_t'(vsel[1]); end
				VS_X2B: begin op_a = osr_pkg::acc_t'(u_q[1]); op_b = osr_pkg::mb_t'(vsel[0]); end
				VS_T0, VS_T1, VS_T2: begin
					op_a = cr_q[jt];
					op_b = osr_pkg::mb_t'({6'b0, c_q});
				end
				VS_DU0, VS_DU1, VS_DU2: begin
					op_a = d_q;
					op_b = u_q[jr];
				end
				default: begin
					op_a = k_q;
					op_b = osr_pkg::mb_t'(vsel[jr]);
				end
			endcase
		end
	end

	assign mul_start = (state_q == ST_SETUP || state_q == ST_VEC) && !issued_q;

	osr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign p_r15   = osr_pkg::rnd(mul_p, 15);
	assign p2_r15  = osr_pkg::rnd(mul_p <<< 1, 15);
	assign k_val   = osr_pkg::rnd(mul_p, 30 - FRAC_BITS) - osr_pkg::rnd(sum_q, FRAC_BITS);
	assign d_val   = osr_pkg::rnd(sum_q + mul_p, FRAC_BITS);
	assign res_val = osr_pkg::sat20(osr_pkg::rnd(sum_q + mul_p + cr_q[jr], FRAC_BITS));

	assign req.ready = (state_q == ST_IDLE);
	assign acc_req   = req.valid && (state_q == ST_IDLE);
	assign out_free  = !rv_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			vi_q     <= '0;
			issued_q <= 1'b0;
			c_q      <= 16'd23170;
			s_q      <= 16'd23170;
			rv_q     <= 1'b0;
			pos_q[0] <= -ONE_V;
			pos_q[1] <= '0;
			pos_q[2] <= '0;
			for (int i = 0; i < NUM_DIRS; i++) begin
				for (int j = 0; j < 3; j++) begin
					axis_q[i][j] <= osr_pkg::base_axis(3'(i), 2'(j), ONE_V, R_V);
				end
			end
		end else begin
			if (wr_cfg && pready) begin
				if (paddr[2]) begin
					s_q <= pwdata[15:0];
				end else begin
					c_q <= pwdata[15:0];
				end
			end
			if (rsp.valid && rsp.ready) begin
				rv_q <= 1'b0;
			end
			if (mul_start) begin
				issued_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_req) begin
						step_q <= '0;
						vi_q   <= '0;
						if (!req.cmd) begin
							pos_q[0] <= req.load_x;
							pos_q[1] <= req.load_y;
							pos_q[2] <= req.load_z;
							state_q  <= ST_DONE;
						end else if (int'(req.direction) < NUM_DIRS) begin
							for (int j = 0; j < 3; j++) begin
								a_q[j] <= axis_q[dir_idx][j];
							end
							state_q <= ST_SETUP;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SETUP: begin
					if (mul_done) begin
						issued_q <= 1'b0;
						step_q   <= step_q + 1'b1;
						case (step_q)
							SU_U0, SU_U1, SU_U2: u_q[step_q[1:0]] <= p_r15[osr_pkg::MB_W-1:0];
							SU_UU0: sum_q <= mul_p;
							SU_UU1, SU_UU2: sum_q <= sum_q + mul_p;
							default: begin
								k_q     <= k_val;
								step_q  <= '0;
								state_q <= ST_VEC;
							end
						endcase
					end
				end
				ST_VEC: begin
					if (mul_done) begin
						issued_q <= 1'b0;
						step_q   <= step_q + 1'b1;
						case (step_q)
							VS_DOT0, VS_X0A, VS_X1A, VS_X2A: sum_q <= mul_p;
							VS_DOT1: sum_q <= sum_q + mul_p;
							VS_DOT2: d_q <= d_val;
							VS_X0B: cr_q[0] <= sum_q - mul_p;
							VS_X1B: cr_q[1] <= sum_q - mul_p;
							VS_X2B: cr_q[2] <= sum_q - mul_p;
							VS_T0, VS_T1, VS_T2: cr_q[jt] <= p2_r15;
							VS_DU0, VS_DU1, VS_DU2: sum_q <= mul_p <<< 1;
							default: begin
								if (vi_q == '0) begin
									pos_q[jr] <= res_val;
								end else begin
									axis_q[ax_idx][jr] <= res_val;
								end
								if (step_q == VS_KV2) begin
									step_q <= '0;
									if (int'(vi_q) == NUM_DIRS) begin
										state_q <= ST_DONE;
									end else begin
										vi_q <= vi_q + 1'b1;
									end
								end
							end
						endcase
					end
				end
				default: begin
					if (out_free) begin
						rv_q    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			ox_q <= pos_q[0];
			oy_q <= pos_q[1];
			oz_q <= pos_q[2];
		end
	end

	assign rsp.valid = rv_q;
	assign rsp.out_x = ox_q;
	assign rsp.out_y = oy_q;
	assign rsp.out_z = oz_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_SETUP || state_q == ST_VEC))
		else $error("multiplier result outside a rotation");
	a_vi_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VEC) |-> (int'(vi_q) <= NUM_DIRS))
		else $error("vector index out of range");
	a_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !issued_q)
		else $error("ready while a product is in flight");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for orientation_step_rotator: loads, quaternion rotate steps, APB config.
module testbench;

	localparam logic [2:0] ADDR_HALF_COS = 3'd0;
	localparam logic [2:0] ADDR_HALF_SIN = 3'd4;
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_ROTATE = 1'b1;
	localparam int NDIR = 8;
	localparam int FB = 16;
	localparam int ROT_CYCLES = 4100;
	localparam int HOLDOFF_CYCLES = 300;

	typedef struct {
		logic          cmd;
		logic [2:0]    direction;
		osr_pkg::vec_t lx;
		osr_pkg::vec_t ly;
		osr_pkg::vec_t lz;
	} step_item_t;

	typedef struct {
		osr_pkg::vec_t x;
		osr_pkg::vec_t y;
		osr_pkg::vec_t z;
	} pos_t;

	typedef longint triple_t[3];

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	osr_req_if req_ch();
	osr_rsp_if rsp_ch();

	orientation_step_rotator dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req_ch), .rsp(rsp_ch)
	);

	step_item_t pending_steps[$];
	pos_t       expected_pos[$];
	int         mismatches;
	int         positions_seen;
	int         holdoff_left;
	bit         holdoff_done;

	// shadow of the block
	longint cur_pos[3];
	longint axes[NDIR][3];
	longint cos_q;
	longint sin_q;

	bit calm;
	assign calm = (positions_seen >= 100) && (positions_seen < 200);

	function automatic longint round_shift(longint x, int sh);
		if (sh == 0) begin
			return x;
		end
		return (x + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clamp20(longint x);
		if (x > 524287) begin
			return 524287;
		end
		if (x < -524288) begin
			return -524288;
		end
		return x;
	endfunction

	function automatic void quat_rotate(input triple_t v, input triple_t a, output triple_t res);
		longint u[3];
		longint cr[3];
		longint d;
		longint k;
		longint t;
		for (int i = 0; i < 3; i++) begin
			u[i] = round_shift(a[i] * sin_q, 15);
		end
		d = round_shift(u[0] * v[0] + u[1] * v[1] + u[2] * v[2], FB);
		k = round_shift(cos_q * cos_q, 30 - FB)
			- round_shift(u[0] * u[0] + u[1] * u[1] + u[2] * u[2], FB);
		cr[0] = u[1] * v[2] - u[2] * v[1];
		cr[1] = u[2] * v[0] - u[0] * v[2];
		cr[2] = u[0] * v[1] - u[1] * v[0];
		for (int i = 0; i < 3; i++) begin
			t = round_shift(2 * cos_q * cr[i], 15);
			res[i] = clamp20(round_shift(2 * d * u[i] + k * v[i] + t, FB));
		end
	endfunction

	function automatic pos_t predict_step(step_item_t it);
		triple_t ax;
		triple_t v;
		triple_t res;
		pos_t p;
		if (it.cmd == CMD_LOAD) begin
			cur_pos[0] = it.lx;
			cur_pos[1] = it.ly;
			cur_pos[2] = it.lz;
		end else if (int'(it.direction) < NDIR) begin
			ax = axes[it.direction];
			v = cur_pos;
			quat_rotate(v, ax, res);
			cur_pos = res;
			for (int i = 0; i < NDIR; i++) begin
				v = axes[i];
				quat_rotate(v, ax, res);
				axes[i] = res;
			end
		end
		p.x = osr_pkg::vec_t'(cur_pos[0]);
		p.y = osr_pkg::vec_t'(cur_pos[1]);
		p.z = osr_pkg::vec_t'(cur_pos[2]);
		return p;
	endfunction

	function automatic void shadow_reset();
		longint one;
		longint r;
		longint ys[8];
		longint zs[8];
		one = 65536;
		r = round_shift(osr_pkg::INV_SQRT2_Q30, 30 - FB);
		ys = '{one, r, 0, -r, -one, -r, 0, r};
		zs = '{0, -r, -one, -r, 0, r, one, r};
		for (int i = 0; i < NDIR; i++) begin
			axes[i][0] = 0;
			axes[i][1] = ys[i % 8];
			axes[i][2] = zs[i % 8];
		end
		cur_pos = '{-one, 0, 0};
		cos_q = 23170;
		sin_q = 23170;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				step_item_t acc;
				acc.cmd = req_ch.cmd;
				acc.direction = req_ch.direction;
				acc.lx = req_ch.load_x;
				acc.ly = req_ch.load_y;
				acc.lz = req_ch.load_z;
				expected_pos.push_back(predict_step(acc));
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_steps.size() > 0 && (calm || $urandom_range(0, 99) >= 37)) begin
					step_item_t it;
					it = pending_steps.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.cmd <= it.cmd;
					req_ch.direction <= it.direction;
					req_ch.load_x <= it.lx;
					req_ch.load_y <= it.ly;
					req_ch.load_z <= it.lz;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted in cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left <= 0;
			holdoff_done <= 1'b0;
		end else begin
			if (holdoff_left > 0) begin
				holdoff_left <= holdoff_left - 1;
			end else if (!holdoff_done && positions_seen >= 40) begin
				holdoff_done <= 1'b1;
				holdoff_left <= HOLDOFF_CYCLES;
			end
		end
	end

	// monitor and receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				pos_t e;
				positions_seen <= positions_seen + 1;
				if (expected_pos.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: x=%0d y=%0d z=%0d",
							rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z);
				end else begin
					e = expected_pos.pop_front();
					if (e.x !== rsp_ch.out_x || e.y !== rsp_ch.out_y || e.z !== rsp_ch.out_z) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp (%0d,%0d,%0d) got (%0d,%0d,%0d)",
								e.x, e.y, e.z, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z);
					end
				end
			end
			if (holdoff_left > 0 || (!holdoff_done && positions_seen >= 40)) begin
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 37);
			end
		end
	end

	function automatic osr_pkg::vec_t pick_coord();
		case ($urandom_range(0, 4))
			0: return osr_pkg::vec_t'($urandom);
			1: return 20'sd524287;
			2: return -20'sd524288;
			default: return osr_pkg::vec_t'($signed($urandom_range(0, 262144)) - 131072);
		endcase
	endfunction

	function automatic step_item_t make_load(osr_pkg::vec_t x, osr_pkg::vec_t y,
		osr_pkg::vec_t z);
		step_item_t it;
		it.cmd = CMD_LOAD;
		it.direction = 3'($urandom);
		it.lx = x;
		it.ly = y;
		it.lz = z;
		return it;
	endfunction

	function automatic step_item_t make_rotate(logic [2:0] d);
		step_item_t it;
		it.cmd = CMD_ROTATE;
		it.direction = d;
		it.lx = osr_pkg::vec_t'($urandom);
		it.ly = osr_pkg::vec_t'($urandom);
		it.lz = osr_pkg::vec_t'($urandom);
		return it;
	endfunction

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 22)
				pending_steps.push_back(make_rotate(3'($urandom)));
			else
				pending_steps.push_back(make_load(pick_coord(), pick_coord(), pick_coord()));
		end
	endtask

	task automatic apb_write(logic [2:0] addr, logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_HALF_COS)
			cos_q = value;
		else
			sin_q = value;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_steps.size() > 0 || req_ch.valid || expected_pos.size() > 0);
	endtask

	task automatic set_coefs(logic [15:0] c, logic [15:0] s);
		drain();
		apb_write(ADDR_HALF_COS, c);
		apb_write(ADDR_HALF_SIN, s);
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_LOAD;
		req_ch.direction = '0;
		req_ch.load_x = '0;
		req_ch.load_y = '0;
		req_ch.load_z = '0;
		rsp_ch.ready = 1'b0;
		mismatches = 0;
		positions_seen = 0;
		shadow_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: rotate from reset position, field extremes, every axis
		pending_steps.push_back(make_rotate(3'd0));
		pending_steps.push_back(make_load(20'sd524287, -20'sd524288, 20'sd0));
		pending_steps.push_back(make_load(-20'sd524288, 20'sd524287, -20'sd1));
		pending_steps.push_back(make_load(20'sd65536, 20'sd0, 20'sd0));
		for (int d = 0; d < 8; d++) begin
			pending_steps.push_back(make_rotate(3'(d)));
		end
		pending_steps.push_back(make_load(20'sd524287, 20'sd524287, 20'sd524287));
		pending_steps.push_back(make_rotate(3'd7));
		pending_steps.push_back(make_load(20'sd0, 20'sd0, 20'sd0));
		pending_steps.push_back(make_rotate(3'd3));
		queue_random(200);

		set_coefs(16'd32768, 16'd0);
		queue_random(80);
		set_coefs(16'd0, 16'd32768);
		queue_random(80);
		set_coefs(16'($urandom_range(20000, 32768)), 16'($urandom_range(0, 20000)));
		queue_random(120);
		set_coefs(16'd23170, 16'd23170);
		queue_random(100);
		// coefficients above one scale and saturate; zero collapses everything
		set_coefs(16'd65535, 16'd65535);
		queue_random(60);
		set_coefs(16'd0, 16'd0);
		queue_random(40);

		drain();
		repeat (ROT_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#150000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
